// ===== hw/rtl/char_lcd_nibble_sequencer_defines.svh =====
// Assertion macros for the character LCD nibble sequencer.
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define CLNS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: %m");
// Next-cycle implication, checked outside reset.
`define CLNS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: %m");
`else
`define CLNS_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define CLNS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== hw/rtl/clns_pkg.sv =====
// Shared widths, mode codes, LCD command bytes and lookup tables.
package clns_pkg;

   localparam int MODE_W   = 3;
   localparam int VALUE_W  = 16;
   localparam int ROW_W    = 3;
   localparam int COLUMN_W = 5;
   localparam int NIBBLE_W = 4;

   localparam logic [MODE_W-1:0] MODE_INIT     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_CHAR     = 3'd1;
   localparam logic [MODE_W-1:0] MODE_GOTO     = 3'd2;
   localparam logic [MODE_W-1:0] MODE_UNSIGNED = 3'd3;
   localparam logic [MODE_W-1:0] MODE_SIGNED   = 3'd4;
   localparam logic [MODE_W-1:0] MODE_RAW      = 3'd5;

   localparam logic [7:0] CHAR_FORM_FEED = 8'h0C;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [7:0] CHAR_MINUS     = 8'h2D;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;

   localparam logic [7:0] CMD_FUNCTION_SET = 8'h20 | (8'h02 << 2);
   localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
   localparam logic [7:0] CMD_CLEAR        = 8'h01;
   localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
   localparam logic [7:0] CMD_LINE2_HOME   = 8'hC0;
   localparam logic [7:0] CMD_CURSOR_LEFT  = 8'h10;

   localparam logic [3:0] WAKE_NIBBLE  = 4'h3;
   localparam logic [3:0] FOUR_BIT_NIB = 4'h2;

   // Power-up sequence: three wake nibbles, 4-bit switch, then four set-up bytes.
   function automatic logic [NIBBLE_W-1:0] init_nibble(input logic [3:0] idx);
      logic [NIBBLE_W-1:0] nib;
      case (idx)
         4'd0, 4'd1, 4'd2: nib = WAKE_NIBBLE;
         4'd3:  nib = FOUR_BIT_NIB;
         4'd4:  nib = CMD_FUNCTION_SET[7:4];
         4'd5:  nib = CMD_FUNCTION_SET[3:0];
         4'd6:  nib = CMD_DISPLAY_ON[7:4];
         4'd7:  nib = CMD_DISPLAY_ON[3:0];
         4'd8:  nib = CMD_CLEAR[7:4];
         4'd9:  nib = CMD_CLEAR[3:0];
         4'd10: nib = CMD_ENTRY_MODE[7:4];
         4'd11: nib = CMD_ENTRY_MODE[3:0];
         default: nib = '0;
      endcase
      return nib;
   endfunction

   // DDRAM address of column one on each display line.
   function automatic logic [7:0] row_base(input logic [1:0] r);
      logic [7:0] base;
      case (r)
         2'd0: base = 8'h80;
         2'd1: base = 8'hC0;
         2'd2: base = 8'h94;
         2'd3: base = 8'hD4;
         default: base = 8'h80;
      endcase
      return base;
   endfunction

endpackage

// ===== hw/rtl/clns_if.sv =====
// Request and response channel interfaces of the LCD nibble sequencer.
interface clns_req_if;
   import clns_pkg::*;
   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [VALUE_W-1:0]  value;
   logic [ROW_W-1:0]    row;
   logic [COLUMN_W-1:0] column;
   modport source (output valid, mode, value, row, column, input ready);
   modport sink   (input valid, mode, value, row, column, output ready);
endinterface

interface clns_rsp_if;
   import clns_pkg::*;
   logic                valid;
   logic                ready;
   logic                rs;
   logic [NIBBLE_W-1:0] nibble;
   logic                last;
   modport source (output valid, rs, nibble, last, input ready);
   modport sink   (input valid, rs, nibble, last, output ready);
endinterface

// ===== hw/rtl/char_lcd_nibble_sequencer.sv =====
// Top level: turns one LCD request into the 4-bit bus writes it needs.
`include "char_lcd_nibble_sequencer_defines.svh"

// Takes one request at a time and plays out its nibbles on the response
// channel, high nibble of each byte first, with last set on the final one.
// The request side is ready only while the sequencer is idle. Init sends
// twelve nibbles; text, goto and raw requests send two nibbles. Number
// requests first run shift-and-add-3 binary to BCD conversion on one shared
// adjust/shift unit (one input bit per cycle), then send two nibbles per
// digit plus two for a minus sign, up to twelve nibbles. Nibbles go out
// back to back while the response side is ready; back-pressure stalls
// them. The response register lets the next request be taken while the
// final nibble of the previous one is still waiting. Unused modes are
// accepted and dropped with no response.
module char_lcd_nibble_sequencer #(
   parameter int COLUMNS = 20
) (
   input logic         clock,
   input logic         reset,
   clns_req_if.sink    req_chan,
   clns_rsp_if.source  rsp_chan
);
   import clns_pkg::*;

   localparam logic [5:0] COL_MAX = 6'(COLUMNS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_EMIT
   } state_type;

   state_type            state_ff, state_in;
   logic [MODE_W-1:0]    mode_ff, mode_in;
   logic [7:0]           byte_ff, byte_in;
   logic                 rs_ff, rs_in;
   logic                 neg_ff, neg_in;
   logic [VALUE_W-1:0]   bin_ff, bin_in;
   logic [19:0]          bcd_ff, bcd_in;
   logic [3:0]           step_ff, step_in;
   logic [3:0]           nib_ff, nib_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_rs_ff, rsp_rs_in;
   logic [NIBBLE_W-1:0]  rsp_nibble_ff, rsp_nibble_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 req_take;
   logic                 slot_free;
   logic [1:0]           row_sel;
   logic [5:0]           col_sat;
   logic [7:0]           goto_byte;
   logic [7:0]           char_byte;
   logic                 char_rs;
   logic [19:0]          bcd_adj;
   logic [2:0]           num_digits;
   logic [3:0]           last_idx;
   logic [2:0]           byte_idx;
   logic [2:0]           digit_pos;
   logic [2:0]           digit_sel;
   logic [3:0]           digit;
   logic [7:0]           emit_byte;
   logic                 emit_rs;
   logic [NIBBLE_W-1:0]  emit_nibble;

   assign req_chan.ready  = (state_ff == ST_IDLE);
   assign req_take        = req_chan.valid && req_chan.ready;
   assign slot_free       = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.rs     = rsp_rs_ff;
   assign rsp_chan.nibble = rsp_nibble_ff;
   assign rsp_chan.last   = rsp_last_ff;

   // Goto address: clamp row to 1..4 and column to 1..COLUMNS.
   always_comb begin
      if (req_chan.row == 3'd0) begin
         row_sel = 2'd0;
      end else if (req_chan.row > 3'd4) begin
         row_sel = 2'd3;
      end else begin
         row_sel = 2'(req_chan.row - 3'd1);
      end
      col_sat = {1'b0, req_chan.column};
      if (col_sat == 6'd0) begin
         col_sat = 6'd1;
      end else if (col_sat > COL_MAX) begin
         col_sat = COL_MAX;
      end
      goto_byte = row_base(row_sel) + {2'b00, col_sat} - 8'd1;
   end

   // Text characters: the three control codes map to display commands.
   always_comb begin
      char_byte = req_chan.value[7:0];
      char_rs   = 1'b1;
      case (req_chan.value[7:0])
         CHAR_FORM_FEED: begin
            char_byte = CMD_CLEAR;
            char_rs   = 1'b0;
         end
         CHAR_NEWLINE: begin
            char_byte = CMD_LINE2_HOME;
            char_rs   = 1'b0;
         end
         CHAR_BACKSPACE: begin
            char_byte = CMD_CURSOR_LEFT;
            char_rs   = 1'b0;
         end
         default: begin
            char_byte = req_chan.value[7:0];
            char_rs   = 1'b1;
         end
      endcase
   end

   // Shared conversion unit: add 3 to every BCD digit of five or more.
   always_comb begin
      for (int i = 0; i < 5; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   // Digit count without leading zeros; zero still prints one digit.
   always_comb begin
      if (bcd_ff[19:16] != 4'd0) begin
         num_digits = 3'd5;
      end else if (bcd_ff[15:12] != 4'd0) begin
         num_digits = 3'd4;
      end else if (bcd_ff[11:8] != 4'd0) begin
         num_digits = 3'd3;
      end else if (bcd_ff[7:4] != 4'd0) begin
         num_digits = 3'd2;
      end else begin
         num_digits = 3'd1;
      end
   end

   // Pick the byte and register select for the current nibble slot.
   always_comb begin
      byte_idx  = nib_ff[3:1];
      digit_pos = byte_idx - {2'b00, neg_ff};
      digit_sel = num_digits - 3'd1 - digit_pos;
      case (digit_sel)
         3'd0: digit = bcd_ff[3:0];
         3'd1: digit = bcd_ff[7:4];
         3'd2: digit = bcd_ff[11:8];
         3'd3: digit = bcd_ff[15:12];
         3'd4: digit = bcd_ff[19:16];
         default: digit = 4'd0;
      endcase
      emit_byte = byte_ff;
      emit_rs   = rs_ff;
      last_idx  = 4'd1;
      case (mode_ff)
         MODE_INIT: begin
            last_idx = 4'd11;
            emit_rs  = 1'b0;
         end
         MODE_UNSIGNED, MODE_SIGNED: begin
            last_idx = {num_digits + {2'b00, neg_ff}, 1'b0} - 4'd1;
            emit_rs  = 1'b1;
            if (neg_ff && (byte_idx == 3'd0)) begin
               emit_byte = CHAR_MINUS;
            end else begin
               emit_byte = CHAR_ZERO | {4'h0, digit};
            end
         end
         default: begin
            last_idx = 4'd1;
         end
      endcase
      if (mode_ff == MODE_INIT) begin
         emit_nibble = init_nibble(nib_ff);
      end else if (nib_ff[0] == 1'b0) begin
         emit_nibble = emit_byte[7:4];
      end else begin
         emit_nibble = emit_byte[3:0];
      end
   end

   // Sequencer next-state logic.
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      byte_in       = byte_ff;
      rs_in         = rs_ff;
      neg_in        = neg_ff;
      bin_in        = bin_ff;
      bcd_in        = bcd_ff;
      step_in       = step_ff;
      nib_in        = nib_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_rs_in     = rsp_rs_ff;
      rsp_nibble_in = rsp_nibble_ff;
      rsp_last_in   = rsp_last_ff;

      // Drop the held nibble once the sink takes it.
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               mode_in = req_chan.mode;
               nib_in  = 4'd0;
               step_in = 4'd0;
               bcd_in  = '0;
               neg_in  = 1'b0;
               case (req_chan.mode)
                  MODE_INIT: begin
                     state_in = ST_EMIT;
                  end
                  MODE_CHAR: begin
                     byte_in  = char_byte;
                     rs_in    = char_rs;
                     state_in = ST_EMIT;
                  end
                  MODE_GOTO: begin
                     byte_in  = goto_byte;
                     rs_in    = 1'b0;
                     state_in = ST_EMIT;
                  end
                  MODE_UNSIGNED: begin
                     bin_in   = req_chan.value;
                     state_in = ST_CONVERT;
                  end
                  MODE_SIGNED: begin
                     neg_in = req_chan.value[VALUE_W-1];
                     if (req_chan.value[VALUE_W-1]) begin
                        bin_in = VALUE_W'(-req_chan.value);
                     end else begin
                        bin_in = req_chan.value;
                     end
                     state_in = ST_CONVERT;
                  end
                  MODE_RAW: begin
                     byte_in  = req_chan.value[7:0];
                     rs_in    = 1'b0;
                     state_in = ST_EMIT;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_CONVERT: begin
            // Shift one input bit into the adjusted BCD digits.
            bcd_in  = {bcd_adj[18:0], bin_ff[VALUE_W-1]};
            bin_in  = {bin_ff[VALUE_W-2:0], 1'b0};
            step_in = step_ff + 4'd1;
            if (step_ff == 4'(VALUE_W - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_rs_in     = emit_rs;
               rsp_nibble_in = emit_nibble;
               rsp_last_in   = (nib_ff == last_idx);
               nib_in        = nib_ff + 4'd1;
               if (nib_ff == last_idx) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      byte_ff       <= byte_in;
      rs_ff         <= rs_in;
      neg_ff        <= neg_in;
      bin_ff        <= bin_in;
      bcd_ff        <= bcd_in;
      step_ff       <= step_in;
      nib_ff        <= nib_in;
      rsp_rs_ff     <= rsp_rs_in;
      rsp_nibble_ff <= rsp_nibble_in;
      rsp_last_ff   <= rsp_last_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The nibble counter never runs past the final slot of the request.
   `CLNS_ASSERT_IMPLY(a_nib_in_range, clock, reset,
      state_ff == ST_EMIT, nib_ff <= last_idx)

   // After sixteen shifts every input bit has moved into the BCD digits.
   `CLNS_ASSERT_NEXT(a_convert_drained, clock, reset,
      state_ff == ST_CONVERT && step_ff == 4'(VALUE_W - 1), bin_ff == '0)

   // Converted digits are all proper decimal digits while they are sent.
   `CLNS_ASSERT_IMPLY(a_bcd_digits_valid, clock, reset,
      state_ff == ST_EMIT && (mode_ff == MODE_UNSIGNED || mode_ff == MODE_SIGNED),
      bcd_ff[3:0] <= 4'd9 && bcd_ff[7:4] <= 4'd9 && bcd_ff[11:8] <= 4'd9 &&
      bcd_ff[15:12] <= 4'd9 && bcd_ff[19:16] <= 4'd9)

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the character LCD nibble sequencer.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import clns_pkg::*;

   localparam int COLUMNS       = 20;
   localparam int STALL_LIMIT   = 2000;  // cycles with no handshake on either side
   localparam int DRAIN_CYCLES  = 40;    // covers the longest number request
   localparam int RANDOM_ITEMS  = 305;
   localparam int PAUSE_EVERY   = 75;
   localparam int USE_PREDICTOR = -1;

   // Mode codes the block accepts and drops without a response.
   localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

   // One 4-bit bus write as the block emits it.
   typedef struct packed {
      logic                rs;
      logic [NIBBLE_W-1:0] nibble;
      logic                last;
   } lcd_write_type;

   // One directed request. When count is not USE_PREDICTOR, the expected
   // writes are typed in: nibbles left-aligned in nibs, register select
   // left-aligned in rs_bits.
   typedef struct {
      logic [MODE_W-1:0]   mode;
      logic [VALUE_W-1:0]  value;
      logic [ROW_W-1:0]    row;
      logic [COLUMN_W-1:0] column;
      int                  count;
      logic [47:0]         nibs;
      logic [11:0]         rs_bits;
   } lcd_request_row_type;

   logic clock;
   logic reset;

   clns_req_if req_bus ();
   clns_rsp_if rsp_bus ();

   char_lcd_nibble_sequencer #(
      .COLUMNS (COLUMNS)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Bus writes still owed by the block, oldest first.
   lcd_write_type pending_writes[$];

   int  error_count  = 0;
   int  writes_seen  = 0;
   int  mode_hits[8] = '{default: 0};
   bit  calm         = 1'b0;  // no idling on either side while set

   // Directed table: power-up, every text special, goto corners and clamps,
   // number extremes including the most negative value, raw bytes, spare modes.
   lcd_request_row_type directed_rows [25] = '{
      '{MODE_INIT,     16'h0000, 3'd1, 5'd1,  12, 48'h3332_280C_0106, 12'h000},
      '{MODE_CHAR,     16'h0041, 3'd1, 5'd1,  USE_PREDICTOR, 48'h0, 12'h0},
      '{MODE_CHAR,     16'hFF41, 3'd7, 5'd31, USE_PREDICTOR, 48'h0, 12'h0},
      '{MODE_CHAR,     16'h000C, 3'd1, 5'd1,  2,  48'h0100_0000_0000, 12'h000},
      '{MODE_CHAR,     16'h000A, 3'd1, 5'd1,  2,  48'hC000_0000_0000, 12'h000},
      '{MODE_CHAR,     16'h0008, 3'd1, 5'd1,  2,  48'h1000_0000_0000, 12'h000},
      '{MODE_CHAR,     16'h00FF, 3'd1, 5'd1,  2,  48'hFF00_0000_0000, 12'hC00},
      '{MODE_CHAR,     16'h0000, 3'd1, 5'd1,  2,  48'h0000_0000_0000, 12'hC00},
      '{MODE_GOTO,     16'h0000, 3'd1, 5'd1,  2,  48'h8000_0000_0000, 12'h000},
      '{MODE_GOTO,     16'hFFFF, 3'd4, 5'd20, 2,  48'hE700_0000_0000, 12'h000},
      '{MODE_GOTO,     16'h0000, 3'd0, 5'd0,  USE_PREDICTOR, 48'h0, 12'h0},
      '{MODE_GOTO,     16'h0000, 3'd7, 5'd31, USE_PREDICTOR, 48'h0, 12'h0},
      '{MODE_GOTO,     16'h1234, 3'd2, 5'd10, USE_PREDICTOR, 48'h0, 12'h0},
      '{MODE_GOTO,     16'h0000, 3'd3, 5'd5,  USE_PREDICTOR, 48'h0, 12'h0},
      '{MODE_UNSIGNED, 16'h0000, 3'd1, 5'd1,  2,  48'h3000_0000_0000, 12'hC00},
      '{MODE_UNSIGNED, 16'hFFFF, 3'd1, 5'd1,  10, 48'h3635_3533_3500, 12'hFFC},
      '{MODE_UNSIGNED, 16'd10,   3'd1, 5'd1,  USE_PREDICTOR, 48'h0, 12'h0},
      '{MODE_SIGNED,   16'h8000, 3'd1, 5'd1,  12, 48'h2D33_3237_3638, 12'hFFF},
      '{MODE_SIGNED,   16'hFFFF, 3'd1, 5'd1,  USE_PREDICTOR, 48'h0, 12'h0},
      '{MODE_SIGNED,   16'h7FFF, 3'd1, 5'd1,  USE_PREDICTOR, 48'h0, 12'h0},
      '{MODE_SIGNED,   16'h0000, 3'd1, 5'd1,  USE_PREDICTOR, 48'h0, 12'h0},
      '{MODE_RAW,      16'h00FF, 3'd1, 5'd1,  2,  48'hFF00_0000_0000, 12'h000},
      '{MODE_RAW,      16'h5501, 3'd1, 5'd1,  USE_PREDICTOR, 48'h0, 12'h0},
      '{MODE_SPARE_6,  16'h0041, 3'd1, 5'd1,  0,  48'h0, 12'h000},
      '{MODE_SPARE_7,  16'hFFFF, 3'd7, 5'd31, 0,  48'h0, 12'h000}
   };

   // Free-running clock, 8 ns period.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Print one line per mismatch and count every one.
   task automatic report_mismatch(input string msg);
      error_count++;
      $display("%0t ERROR: %s", $time, msg);
   endtask

   // Idle length: mostly none, sometimes a few cycles, rarely a long stretch.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 60)
         return 0;
      else if (roll < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(10, 40);
   endfunction

   // ---------------------------------------------------------------------
   // Predictor: append the bus writes one request causes.
   // ---------------------------------------------------------------------
   task automatic owe_nibble(input logic rs, input logic [3:0] nib);
      pending_writes.push_back('{rs: rs, nibble: nib, last: 1'b0});
   endtask

   task automatic owe_byte(input logic rs, input logic [7:0] b);
      owe_nibble(rs, b[7:4]);
      owe_nibble(rs, b[3:0]);
   endtask

   // Decimal digits, most significant first, no leading zeros.
   task automatic owe_decimal(input logic [16:0] magnitude);
      logic [3:0]  digits [5];
      logic [16:0] rest;
      int          cnt;
      rest = magnitude;
      cnt  = 0;
      do begin
         digits[cnt] = 4'(rest % 17'd10);
         rest        = rest / 17'd10;
         cnt++;
      end while (rest != 0 && cnt < 5);
      while (cnt > 0) begin
         cnt--;
         owe_byte(1'b1, CHAR_ZERO + {4'd0, digits[cnt]});
      end
   endtask

   task automatic predict_lcd_writes(input logic [MODE_W-1:0]   mode,
                                     input logic [VALUE_W-1:0]  value,
                                     input logic [ROW_W-1:0]    row,
                                     input logic [COLUMN_W-1:0] column);
      int            owed_before;
      int            line;
      int            col;
      logic [7:0]    line_base;
      lcd_write_type tail;
      owed_before = pending_writes.size();
      case (mode)
         MODE_INIT: begin
            owe_nibble(1'b0, WAKE_NIBBLE);
            owe_nibble(1'b0, WAKE_NIBBLE);
            owe_nibble(1'b0, WAKE_NIBBLE);
            owe_nibble(1'b0, FOUR_BIT_NIB);
            owe_byte(1'b0, CMD_FUNCTION_SET);
            owe_byte(1'b0, CMD_DISPLAY_ON);
            owe_byte(1'b0, CMD_CLEAR);
            owe_byte(1'b0, CMD_ENTRY_MODE);
         end
         MODE_CHAR: begin
            case (value[7:0])
               CHAR_FORM_FEED: owe_byte(1'b0, CMD_CLEAR);
               CHAR_NEWLINE:   owe_byte(1'b0, CMD_LINE2_HOME);
               CHAR_BACKSPACE: owe_byte(1'b0, CMD_CURSOR_LEFT);
               default:        owe_byte(1'b1, value[7:0]);
            endcase
         end
         MODE_GOTO: begin
            // Clamp row to 1..4 and column to 1..COLUMNS.
            line = (row < 1) ? 1 : (row > 4) ? 4 : int'(row);
            col  = (column < 1) ? 1 : (column > COLUMNS) ? COLUMNS : int'(column);
            case (line)
               1:       line_base = 8'h80;
               2:       line_base = 8'hC0;
               3:       line_base = 8'h94;
               default: line_base = 8'hD4;
            endcase
            owe_byte(1'b0, line_base + 8'(col - 1));
         end
         MODE_UNSIGNED: owe_decimal({1'b0, value});
         MODE_SIGNED: begin
            if (value[15]) begin
               owe_byte(1'b1, CHAR_MINUS);
               owe_decimal(17'h10000 - {1'b0, value});
            end else begin
               owe_decimal({1'b0, value});
            end
         end
         MODE_RAW: owe_byte(1'b0, value[7:0]);
         default: ;
      endcase
      // Mark the final write of this request.
      if (pending_writes.size() > owed_before) begin
         tail      = pending_writes.pop_back();
         tail.last = 1'b1;
         pending_writes.push_back(tail);
      end
   endtask

   // ---------------------------------------------------------------------
   // Request driver: present one request, hold it until accepted, then
   // record what it owes. Either idle first, or hold off until drained.
   // ---------------------------------------------------------------------
   task automatic send_request(input logic [MODE_W-1:0]   mode,
                               input logic [VALUE_W-1:0]  value,
                               input logic [ROW_W-1:0]    row,
                               input logic [COLUMN_W-1:0] column,
                               input int                  typed_count,
                               input logic [47:0]         typed_nibs,
                               input logic [11:0]         typed_rs,
                               input bit                  hold_for_drain);
      int gap;
      gap = pick_gap();
      if (hold_for_drain) begin
         // Drop valid and wait until every owed write has come back.
         req_bus.valid <= 1'b0;
         do @(posedge clock); while (pending_writes.size() != 0);
      end else if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.mode   <= mode;
      req_bus.value  <= value;
      req_bus.row    <= row;
      req_bus.column <= column;
      do @(posedge clock); while (!req_bus.ready);
      // Accepted at this edge: record the owed writes now.
      mode_hits[mode]++;
      if (typed_count == USE_PREDICTOR) begin
         predict_lcd_writes(mode, value, row, column);
      end else begin
         for (int i = 0; i < typed_count; i++)
            pending_writes.push_back('{rs: typed_rs[11-i],
                                       nibble: typed_nibs[47-4*i -: 4],
                                       last: (i == typed_count - 1)});
      end
   endtask

   // ---------------------------------------------------------------------
   // Response side: stall ready at random, with calm stretches.
   // ---------------------------------------------------------------------
   initial begin : rsp_ready_drive
      int stall;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = pick_gap();
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   // Compare each accepted write with the oldest one owed.
   always @(posedge clock) begin
      lcd_write_type got;
      lcd_write_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rs: rsp_bus.rs, nibble: rsp_bus.nibble, last: rsp_bus.last};
         if (pending_writes.size() == 0) begin
            report_mismatch($sformatf("unexpected write rs=%0b nibble=%h last=%0b",
                                      got.rs, got.nibble, got.last));
         end else begin
            want = pending_writes.pop_front();
            if (got.rs !== want.rs || got.nibble !== want.nibble ||
                got.last !== want.last)
               report_mismatch($sformatf(
                  "write %0d: got rs=%0b nibble=%h last=%0b, want rs=%0b nibble=%h last=%0b",
                  writes_seen, got.rs, got.nibble, got.last,
                  want.rs, want.nibble, want.last));
         end
         writes_seen++;
      end
   end

   // Watchdog: end the run if neither side moves for too long.
   initial begin : stall_watchdog
      int quiet;
      quiet = 0;
      do @(posedge clock); while (reset);
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t watchdog: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Main sequence: reset, directed table, random requests, drain, verdict.
   // ---------------------------------------------------------------------
   initial begin : stimulus
      logic [MODE_W-1:0]   mode;
      logic [VALUE_W-1:0]  value;
      logic [ROW_W-1:0]    row;
      logic [COLUMN_W-1:0] column;
      int                  roll;
      int                  sent;

      // Drive every input to a known value while reset is held.
      reset          <= 1'b1;
      req_bus.valid  <= 1'b0;
      req_bus.mode   <= '0;
      req_bus.value  <= '0;
      req_bus.row    <= '0;
      req_bus.column <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table.
      foreach (directed_rows[i])
         send_request(directed_rows[i].mode, directed_rows[i].value,
                      directed_rows[i].row, directed_rows[i].column,
                      directed_rows[i].count, directed_rows[i].nibs,
                      directed_rows[i].rs_bits, 1'b0);

      // Random requests; spare modes are sent as noise but not counted.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 49) == 0)
            calm = !calm;
         value  = 16'($urandom);
         row    = 3'($urandom_range(1, 4));
         column = 5'($urandom_range(1, COLUMNS));
         roll   = $urandom_range(0, 99);
         if (roll < 6) begin
            mode = MODE_INIT;
         end else if (roll < 35) begin
            mode = MODE_CHAR;
            // Favor the control characters now and then.
            case ($urandom_range(0, 9))
               0:       value[7:0] = CHAR_FORM_FEED;
               1:       value[7:0] = CHAR_NEWLINE;
               2:       value[7:0] = CHAR_BACKSPACE;
               default: ;
            endcase
         end else if (roll < 50) begin
            mode = MODE_GOTO;
            if ($urandom_range(0, 3) == 0) begin
               row    = 3'($urandom_range(0, 7));
               column = 5'($urandom_range(0, 31));
            end
         end else if (roll < 94) begin
            mode = (roll < 65) ? MODE_UNSIGNED : (roll < 80) ? MODE_SIGNED : MODE_RAW;
            // Mix short, medium and extreme numbers.
            case ($urandom_range(0, 4))
               0: value = 16'($urandom_range(0, 9));
               1: value = 16'($urandom_range(0, 999));
               2: value = 16'hFFFF - 16'($urandom_range(0, 9));
               3: value = 16'h8000 + 16'($urandom_range(0, 9) - 5);
               default: ;
            endcase
         end else begin
            mode = $urandom_range(0, 1) ? MODE_SPARE_7 : MODE_SPARE_6;
         end
         send_request(mode, value, row, column, USE_PREDICTOR, '0, '0,
                      (sent % PAUSE_EVERY) == PAUSE_EVERY - 1);
         if (mode <= MODE_RAW)
            sent++;
      end
      req_bus.valid <= 1'b0;

      // Drain, then give the block time to show any extra writes.
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_writes.size() != 0)
         report_mismatch($sformatf("%0d writes never arrived", pending_writes.size()));

      $display("Covered %0d init, %0d text, %0d goto, %0d unsigned, %0d signed, %0d raw,",
               mode_hits[MODE_INIT], mode_hits[MODE_CHAR], mode_hits[MODE_GOTO],
               mode_hits[MODE_UNSIGNED], mode_hits[MODE_SIGNED], mode_hits[MODE_RAW]);
      $display("%0d spare-mode requests; %0d bus writes checked, %0d mismatches.",
               mode_hits[MODE_SPARE_6] + mode_hits[MODE_SPARE_7], writes_seen,
               error_count);
      if (error_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
